FILE: src/svpwm_duty_modulator_unit_defines.svh
// assertion helpers for the space vector pwm duty modulator
`ifndef SVPWM_DUTY_MODULATOR_UNIT_DEFINES_SVH
`define SVPWM_DUTY_MODULATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SVPWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svpwm check failed");

// next-cycle implication, sampled on clk, off during reset
`define SVPWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svpwm check failed");

`endif

FILE: src/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared types and constants of the svpwm duty modulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svpwm_pkg;

  localparam int XW  = 24;   // command and applied voltage width
  localparam int UW  = 23;   // supply width
  localparam int LW  = 48;   // leg width, 2^-20 input lsb
  localparam int QW  = 24;   // quotient bits of the divider
  localparam int DVD = 64;   // dividend width
  localparam int DVS = 48;   // divisor and remainder width

  localparam logic [19:0] K_HALF_SQRT3 = 20'd908093;
  localparam logic [19:0] K_INV_SQRT3  = 20'd605396;

  localparam logic [2:0] CFG_PHASE_MODE      = 3'd0;
  localparam logic [2:0] CFG_CLAMP_TO_GROUND = 3'd1;
  localparam logic [2:0] CFG_DUTY_RESOLUTION = 3'd2;
  localparam logic [2:0] CFG_DUTY_MINIMAL    = 3'd3;
  localparam logic [2:0] CFG_DUTY_CLEARANCE  = 3'd4;

  // division select: legs a..c, then applied x and y
  localparam logic [2:0] SEL_LEG_C = 3'd2;
  localparam logic [2:0] SEL_X     = 3'd3;
  localparam logic [2:0] SEL_Y     = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_YK, OP_LEGS, OP_MINMAX, OP_DEN, OP_NUM, OP_MUL,
    OP_PROD, OP_DINIT, OP_DSTEP, OP_STORE, OP_AMUL, OP_AMUL2, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic        phase_mode;
    logic        clamp;
    logic [15:0] res;
    logic [14:0] minimal;
    logic [15:0] clearance;
  } cfg_t;

endpackage

FILE: src/svpwm_duty_modulator_unit.sv
// ----------------------------------------------------------------------------
// svpwm_duty_modulator_unit
// space vector pwm duty modulator with min-max common-mode injection
// requests: one at a time; a new request is taken only once the sequencer
//   is back in idle, after the shared radix-2 divider has run 24 steps for
//   each of five divisions and the result has been registered
// reset: synchronous active-low; registers return to resolution 4096,
//   minimal 42, clearance 420, three-phase centered mode, zone history clear
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "svpwm_duty_modulator_unit_defines.svh"

module svpwm_duty_modulator_unit import svpwm_pkg::*; #(
  parameter int DUTY_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input request
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // cmd_x[23:0], cmd_y[47:24], supply_voltage[70:48]
  // result request
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // duty_a, duty_b, duty_c, zone_flags, applied_x, applied_y
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  // resolution is kept masked to the timer width
  localparam logic [15:0] DUTY_MASK = 16'((32'd1 << DUTY_BITS) - 32'd1);

  logic        phase_mode_r;
  logic        clamp_r;
  logic [15:0] res_r;
  logic [14:0] minimal_r;
  logic [15:0] clearance_r;
  cfg_t        cfg;
  cmd_t        cmd;
  stat_t       stat;

  logic [15:0]          duty_a, duty_b, duty_c;
  logic [7:0]           zone_flags;
  logic signed [XW-1:0] applied_x, applied_y;

  // register file, always ready; indexes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_mode_r <= 1'b0;
      clamp_r      <= 1'b0;
      res_r        <= 16'd4096 & DUTY_MASK;
      minimal_r    <= 15'd42;
      clearance_r  <= 16'd420;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PHASE_MODE:      phase_mode_r <= cfg_data[0];
        CFG_CLAMP_TO_GROUND: clamp_r      <= cfg_data[0];
        CFG_DUTY_RESOLUTION: res_r        <= cfg_data & DUTY_MASK;
        CFG_DUTY_MINIMAL:    minimal_r    <= cfg_data[14:0];
        CFG_DUTY_CLEARANCE:  clearance_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = '{phase_mode: phase_mode_r, clamp: clamp_r, res: res_r,
                 minimal: minimal_r, clearance: clearance_r};

  // sequencer
  svpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and output register
  svpwm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg),
    .cmd_x          (in_tdata[23:0]),
    .cmd_y          (in_tdata[47:24]),
    .supply_voltage (in_tdata[70:48]),
    .stat           (stat),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .duty_a         (duty_a),
    .duty_b         (duty_b),
    .duty_c         (duty_c),
    .zone_flags     (zone_flags),
    .applied_x      (applied_x),
    .applied_y      (applied_y)
  );

  // pack result fields, first field lowest
  assign out_tdata = {applied_y, applied_x, zone_flags, duty_c, duty_b, duty_a};

  // an accepted request keeps the input closed while it is worked on
  `SVPWM_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // a result appears exactly as the sequencer returns to idle
  `SVPWM_ASSERT_IMP(a_result_at_idle, $rose(out_tvalid), in_tready)

endmodule

FILE: src/svpwm_ctrl.sv
// ----------------------------------------------------------------------------
// svpwm_ctrl
// sequencer: leg setup, three duty divisions, two applied-voltage divisions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svpwm_ctrl import svpwm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_YK     = 14'b00000000000010,
    S_LEGS   = 14'b00000000000100,
    S_MINMAX = 14'b00000000001000,
    S_DEN    = 14'b00000000010000,
    S_NUM    = 14'b00000000100000,
    S_MUL    = 14'b00000001000000,
    S_PROD   = 14'b00000010000000,
    S_DINIT  = 14'b00000100000000,
    S_DIV    = 14'b00001000000000,
    S_STORE  = 14'b00010000000000,
    S_AMUL   = 14'b00100000000000,
    S_AMUL2  = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] sel_r, sel_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    cmd.sel   = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_YK;
        end
      end
      S_YK: begin
        cmd.op    = OP_YK;
        state_nxt = S_LEGS;
      end
      S_LEGS: begin
        cmd.op    = OP_LEGS;
        state_nxt = S_MINMAX;
      end
      S_MINMAX: begin
        cmd.op    = OP_MINMAX;
        state_nxt = S_DEN;
      end
      S_DEN: begin
        cmd.op    = OP_DEN;
        sel_nxt   = 3'd0;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.op    = OP_NUM;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.op    = OP_PROD;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.op    = OP_DINIT;
        cnt_nxt   = 5'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DSTEP;
        if (cnt_r == 5'(QW - 1)) begin
          state_nxt = S_STORE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_STORE: begin
        cmd.op = OP_STORE;
        if (sel_r == SEL_Y) begin
          state_nxt = S_OUT;
        end else if (sel_r == SEL_LEG_C) begin
          state_nxt = S_AMUL;
        end else if (sel_r == SEL_X) begin
          sel_nxt   = SEL_Y;
          state_nxt = S_DINIT;
        end else begin
          sel_nxt   = sel_r + 3'd1;
          state_nxt = S_NUM;
        end
      end
      S_AMUL: begin
        cmd.op    = OP_AMUL;
        state_nxt = S_AMUL2;
      end
      S_AMUL2: begin
        cmd.op    = OP_AMUL2;
        sel_nxt   = SEL_X;
        state_nxt = S_DINIT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 3'd0;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

FILE: src/svpwm_dp.sv
// ----------------------------------------------------------------------------
// svpwm_dp
// datapath: legs, normalizer, shared radix-2 divider, zone flags, output reg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svpwm_dp import svpwm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  cfg_t                 cfg,
  input  logic signed [XW-1:0] cmd_x,
  input  logic signed [XW-1:0] cmd_y,
  input  logic        [UW-1:0] supply_voltage,
  output stat_t                stat,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic        [15:0]   duty_a,
  output logic        [15:0]   duty_b,
  output logic        [15:0]   duty_c,
  output logic        [7:0]    zone_flags,
  output logic signed [XW-1:0] applied_x,
  output logic signed [XW-1:0] applied_y
);

  logic signed [XW-1:0]  x_r, y_r;
  logic        [UW-1:0]  u_r;
  logic signed [43:0]    yk_r;
  logic signed [LW-1:0]  leg_r [3];
  logic signed [LW-1:0]  mn_r, mx_r;
  logic        [46:0]    den_r;
  logic        [LW-1:0]  num_r;
  logic        [39:0]    plo_r, phi_r;
  logic        [DVD-1:0] prod_r;
  logic        [DVS-1:0] rem_r, dvs_r;
  logic        [QW-1:0]  q_r;
  logic        [15:0]    duty_r [3];
  logic signed [63:0]    anx_r, any_r;
  logic signed [XW-1:0]  ax_r, ay_r;
  logic        [3:0]     last_zone_r;
  logic                  out_valid_r;
  logic        [15:0]    oa_r, ob_r, oc_r;
  logic        [7:0]     oz_r;
  logic signed [XW-1:0]  ox_r, oy_r;

  // leg formation
  logic signed [LW-1:0] xs, ys, x20, x19, yk48;
  logic signed [LW-1:0] leg_nxt [3];
  always_comb begin
    xs   = LW'(x_r);
    ys   = LW'(y_r);
    x20  = xs <<< 20;
    x19  = xs <<< 19;
    yk48 = LW'(yk_r);
    leg_nxt[0] = x20;
    if (cfg.phase_mode) begin
      leg_nxt[1] = ys <<< 20;
      leg_nxt[2] = '0;
    end else begin
      leg_nxt[1] = yk48 - x19;
      leg_nxt[2] = -x19 - yk48;
    end
  end

  // min and max of the three legs
  logic signed [LW-1:0] mn_c, mx_c;
  always_comb begin
    mn_c = leg_r[0];
    mx_c = leg_r[0];
    for (int i = 1; i < 3; i++) begin
      if (leg_r[i] < mn_c) mn_c = leg_r[i];
      if (leg_r[i] > mx_c) mx_c = leg_r[i];
    end
  end

  // normalizer: max of span and supply
  logic [LW-1:0] span_c, uden_c;
  assign span_c = LW'(mx_r - mn_r);
  assign uden_c = LW'({u_r, 20'd0});

  // numerator of one leg
  logic signed [LW-1:0] leg_sel;
  logic signed [49:0]   num_c;
  assign leg_sel = leg_r[cmd.sel[1:0]];
  always_comb begin
    if (cfg.clamp) begin
      num_c = (50'(leg_sel) - 50'(mn_r)) <<< 1;
    end else begin
      num_c = (50'(leg_sel) <<< 1) + $signed({3'b000, den_r})
              - 50'(mn_r) - 50'(mx_r);
    end
  end

  // divider operands
  logic [DVS-1:0] dvx_c, dvy_c, dvs_c;
  logic [DVD-1:0] axm_c, aym_c, dvd_c;
  always_comb begin
    dvx_c = cfg.phase_mode ? DVS'(cfg.res)
                           : DVS'({cfg.res, 1'b0}) + DVS'(cfg.res);
    dvy_c = cfg.phase_mode ? DVS'(cfg.res) : DVS'({cfg.res, 20'd0});
    axm_c = anx_r[63] ? DVD'(-anx_r) : DVD'(anx_r);
    aym_c = any_r[63] ? DVD'(-any_r) : DVD'(any_r);
    case (cmd.sel)
      SEL_X: begin
        dvd_c = axm_c + DVD'(dvx_c >> 1);
        dvs_c = dvx_c;
      end
      SEL_Y: begin
        dvd_c = aym_c + DVD'(dvy_c >> 1);
        dvs_c = dvy_c;
      end
      default: begin
        dvd_c = prod_r;
        dvs_c = {den_r, 1'b0};
      end
    endcase
  end

  // one restoring step
  logic [DVS:0] trial_c;
  logic         fit_c;
  assign trial_c = {rem_r, q_r[QW-1]};
  assign fit_c   = trial_c >= {1'b0, dvs_r};

  // snap of a duty quotient to the rails
  logic signed [17:0] dq_c, lo_c, hi_c;
  logic        [15:0] snap_c;
  always_comb begin
    dq_c = $signed({1'b0, q_r[16:0]});
    lo_c = $signed({3'b000, cfg.minimal});
    hi_c = $signed({2'b00, cfg.res}) - lo_c;
    if (u_r == '0)      snap_c = '0;
    else if (dq_c < lo_c) snap_c = '0;
    else if (dq_c > hi_c) snap_c = cfg.res;
    else                  snap_c = q_r[15:0];
  end

  logic signed [XW-1:0] app_c;
  logic                 neg_c;
  assign neg_c = (cmd.sel == SEL_X) ? anx_r[63] : any_r[63];
  assign app_c = (cfg.res == '0) ? '0
               : (neg_c ? -$signed(q_r) : $signed(q_r));

  // applied-voltage numerators
  logic signed [18:0] da_c, db_c, dc_c, nx_c, ny_c;
  logic signed [23:0] us_c;
  logic signed [42:0] axp_c;
  logic signed [41:0] ayp_c, ay1_c;
  logic signed [62:0] ay2_c;
  always_comb begin
    da_c  = $signed({3'b000, duty_r[0]});
    db_c  = $signed({3'b000, duty_r[1]});
    dc_c  = $signed({3'b000, duty_r[2]});
    us_c  = $signed({1'b0, u_r});
    nx_c  = cfg.phase_mode ? (da_c - dc_c) : ((da_c <<< 1) - db_c - dc_c);
    ny_c  = db_c - dc_c;
    axp_c = nx_c * us_c;
    ayp_c = ny_c * us_c;
    ay1_c = any_r[41:0];
    ay2_c = ay1_c * $signed({1'b0, K_INV_SQRT3});
  end

  // zone flags from the stored duties
  logic signed [17:0] lim_c, dz_c;
  logic        [3:0]  zlo_c;
  always_comb begin
    lim_c = $signed({2'b00, cfg.res}) - $signed({2'b00, cfg.clearance});
    zlo_c = '0;
    for (int i = 0; i < 3; i++) begin
      dz_c = $signed({2'b00, duty_r[i]});
      if (dz_c > lim_c) begin
        if (duty_r[i] < cfg.res) zlo_c[i] = 1'b1;
        else                     zlo_c[3] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r <= cmd_x;
        y_r <= cmd_y;
        u_r <= supply_voltage;
      end
      OP_YK:     yk_r <= y_r * $signed({1'b0, K_HALF_SQRT3});
      OP_LEGS:   for (int i = 0; i < 3; i++) leg_r[i] <= leg_nxt[i];
      OP_MINMAX: begin
        mn_r <= mn_c;
        mx_r <= mx_c;
      end
      OP_DEN:    den_r <= (span_c > uden_c) ? span_c[46:0] : uden_c[46:0];
      OP_NUM:    num_r <= num_c[LW-1:0];
      OP_MUL: begin
        plo_r <= cfg.res * num_r[23:0];
        phi_r <= cfg.res * num_r[47:24];
      end
      OP_PROD:   prod_r <= DVD'(plo_r) + {phi_r, 24'd0};
      OP_DINIT: begin
        rem_r <= DVS'(dvd_c[DVD-1:QW]);
        q_r   <= dvd_c[QW-1:0];
        dvs_r <= dvs_c;
      end
      OP_DSTEP: begin
        rem_r <= fit_c ? DVS'(trial_c - {1'b0, dvs_r}) : trial_c[DVS-1:0];
        q_r   <= {q_r[QW-2:0], fit_c};
      end
      OP_STORE: begin
        case (cmd.sel)
          SEL_X:   ax_r <= app_c;
          SEL_Y:   ay_r <= app_c;
          default: duty_r[cmd.sel[1:0]] <= snap_c;
        endcase
      end
      OP_AMUL: begin
        anx_r <= 64'(axp_c);
        any_r <= 64'(ayp_c);
      end
      OP_AMUL2:  if (!cfg.phase_mode) any_r <= 64'(ay2_c);
      OP_OUT: begin
        oa_r <= duty_r[0];
        ob_r <= duty_r[1];
        oc_r <= duty_r[2];
        oz_r <= {last_zone_r, zlo_c};
        ox_r <= ax_r;
        oy_r <= ay_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_zone_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) begin
        last_zone_r <= zlo_c;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign duty_a        = oa_r;
  assign duty_b        = ob_r;
  assign duty_c        = oc_r;
  assign zone_flags    = oz_r;
  assign applied_x     = ox_r;
  assign applied_y     = oy_r;

endmodule
